FILE: rtl/midi_note_light_envelope_tracker_assert.svh
// Assertion macros for the MIDI note light envelope tracker.
// Bodies refer to clk and rst_n of the module that includes this file.
`ifndef MIDI_NOTE_LIGHT_ENVELOPE_TRACKER_ASSERT_SVH
`define MIDI_NOTE_LIGHT_ENVELOPE_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MNLET_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MNLET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MNLET_ASSERT(label, ante, cons)
`define MNLET_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/mnlet_pkg.sv
// Package for the MIDI note light envelope tracker: sizes, codes, word types.
// Used by mnlet_div and midi_note_light_envelope_tracker; no dependencies.
package mnlet_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int LED_COUNT  = 60;
  localparam int NOTE_AW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int WALK_W     = $clog2(NOTE_COUNT + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;

  localparam logic [15:0] FADE_HOLD_RST  = 16'd500;
  localparam logic [6:0]  FULL_SCALE_RST = 7'd127;

  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_CTRL     = 3'd2;
  localparam logic [2:0] OP_EXPIRE   = 3'd3;
  localparam logic [2:0] OP_QUERY    = 3'd4;

  localparam logic [6:0] SUSTAIN_CTRL   = 7'd64;
  localparam logic [6:0] SUSTAIN_ON_MIN = 7'd64;

  localparam logic [7:0] BRIGHT_BASE = 8'd50;
  localparam logic [7:0] BRIGHT_SPAN = 8'd205;
  localparam logic [7:0] BRIGHT_MAX  = 8'd255;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [6:0]  controller;
    logic [6:0]  cc_value;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        note_active;
    logic        note_fading;
    logic [7:0]  brightness;
    logic [7:0]  hue;
    logic [5:0]  led_index;
    logic        sustain_on;
  } out_t;

  typedef struct packed {
    logic        active;
    logic        fading;
    logic [7:0]  velocity;
    logic [31:0] start_ms;
  } ent_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_resp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_RD,
    ST_MOD,
    ST_DIV1,
    ST_WAIT1,
    ST_MUL2,
    ST_DIV2,
    ST_WAIT2,
    ST_DONE
  } state_t;

  typedef logic [255:0][5:0] led_table_t;

  function automatic led_table_t build_led_table();
    led_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 6'(i % LED_COUNT);
    end
    return t;
  endfunction

  localparam led_table_t LED_TABLE = build_led_table();

endpackage

FILE: rtl/mnlet_div.sv
// Restoring divider, one quotient bit per cycle, for the note tracker.
// Depends on mnlet_pkg for widths and the request and response types.
module mnlet_div import mnlet_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        cnt_r <= DIV_CNT_W'(DIV_NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign resp.busy     = (cnt_r != '0);
  assign resp.done     = done_r;
  assign resp.quotient = quo_r;

endmodule

FILE: rtl/midi_note_light_envelope_tracker.sv
// Channel  Ports                                 Word
// in       in_valid / in_ready / in_data         in_t: op, note, velocity, controller, ...
// out      out_valid / out_ready / out_data      out_t: flags, brightness, hue, led_index
// cfg      cfg_valid / cfg_ready / cfg_index,    fade_hold_ms (0), velocity_full_scale (1)
//          cfg_data
// One word at a time. A dark note needs no division, a lit one or one past its hold time
// one division, and one still fading two, on the one-bit-a-cycle divider. Sustain
// release and expire add a walk over the note memory, one entry a cycle. Reset clears
// per-entry valid bits at once; no clearing pass.
// A waiting result sits in the output register while the next word is accepted and worked
// on. Depends on mnlet_pkg, mnlet_div and midi_note_light_envelope_tracker_assert.svh.
`include "midi_note_light_envelope_tracker_assert.svh"
module midi_note_light_envelope_tracker import mnlet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t                state_r, state_nxt;
  in_t                   item_r;
  logic                  sustain_r;
  logic [15:0]           hold_r;
  logic [6:0]            full_r;
  logic [6:0]            full_eff;

  ent_t                  note_mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] ent_vld_r;
  logic                  rd_en;
  logic [NOTE_AW-1:0]    rd_addr;
  ent_t                  rd_data_r;
  logic                  rd_vld_r;
  ent_t                  rd_ent;
  logic                  wr_en;
  logic [NOTE_AW-1:0]    wr_addr;
  ent_t                  wr_data;

  logic [WALK_W-1:0]     walk_cnt_r;
  logic [WALK_W-1:0]     walk_prev;
  logic                  walk_last;
  logic [31:0]           walk_age;
  logic                  walk_upd;
  ent_t                  walk_ent;

  logic                  note_ok;
  logic                  note_upd;
  ent_t                  ent_mod;
  ent_t                  ent_r;
  logic                  needs_walk;

  logic [15:0]           prod_r;
  logic [23:0]           base_sum;
  logic [7:0]            value_c;
  logic [7:0]            value_r;
  logic [31:0]           elapsed_c;
  logic                  late_c;
  logic [15:0]           elapsed_lo_r;
  logic [23:0]           prod2_r;

  out_t                  res_r;
  logic                  res_load;
  logic                  out_valid_r;
  out_t                  out_data_r;

  div_req_t              div_req;
  div_resp_t             div_resp;

  mnlet_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .resp (div_resp)
  );

  assign full_eff  = (full_r == '0) ? 7'd1 : full_r;
  assign note_ok   = (item_r.note < 8'(NOTE_COUNT));
  assign walk_last = (walk_cnt_r == WALK_W'(NOTE_COUNT));
  assign walk_prev = walk_cnt_r - WALK_W'(1);
  assign rd_ent    = rd_vld_r ? rd_data_r : '0;

  assign needs_walk = (in_data.op == OP_EXPIRE) ||
                      ((in_data.op == OP_CTRL) && (in_data.controller == SUSTAIN_CTRL) &&
                       (in_data.cc_value < SUSTAIN_ON_MIN));

  // expire or release one entry of the walk
  always_comb begin
    walk_age = item_r.now_ms - rd_ent.start_ms;
    walk_ent = rd_ent;
    walk_upd = 1'b0;
    if (item_r.op == OP_EXPIRE) begin
      if (rd_ent.active && rd_ent.fading && (walk_age > {16'b0, hold_r})) begin
        walk_ent.active = 1'b0;
        walk_ent.fading = 1'b0;
        walk_upd        = 1'b1;
      end
    end else if (rd_ent.active && !rd_ent.fading) begin
      walk_ent.fading   = 1'b1;
      walk_ent.start_ms = item_r.now_ms;
      walk_upd          = 1'b1;
    end
  end

  // modify the addressed entry
  always_comb begin
    ent_mod  = rd_ent;
    note_upd = 1'b0;
    case (item_r.op)
      OP_NOTE_ON: begin
        if (note_ok) begin
          ent_mod.active   = 1'b1;
          ent_mod.fading   = 1'b0;
          ent_mod.velocity = item_r.velocity;
          note_upd         = 1'b1;
        end
      end
      OP_NOTE_OFF: begin
        if (note_ok && rd_ent.active) begin
          note_upd = 1'b1;
          if (sustain_r) begin
            ent_mod.fading = 1'b0;
          end else begin
            ent_mod.fading   = 1'b1;
            ent_mod.start_ms = item_r.now_ms;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    base_sum  = div_resp.quotient + 24'(BRIGHT_BASE);
    value_c   = (base_sum > 24'(BRIGHT_MAX)) ? BRIGHT_MAX : base_sum[7:0];
    elapsed_c = item_r.now_ms - ent_r.start_ms;
    late_c    = (elapsed_c >= {16'b0, hold_r});
  end

  // memory ports
  always_comb begin
    rd_en   = ((state_r == ST_WALK) && !walk_last) || ((state_r == ST_RD) && note_ok);
    rd_addr = (state_r == ST_WALK) ? walk_cnt_r[NOTE_AW-1:0] : item_r.note[NOTE_AW-1:0];
    if (state_r == ST_WALK) begin
      wr_en   = (walk_cnt_r != '0) && walk_upd;
      wr_addr = walk_prev[NOTE_AW-1:0];
      wr_data = walk_ent;
    end else begin
      wr_en   = (state_r == ST_MOD) && note_upd;
      wr_addr = item_r.note[NOTE_AW-1:0];
      wr_data = ent_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= note_mem[rd_addr];
      rd_vld_r  <= ent_vld_r[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = needs_walk ? ST_WALK : ST_RD;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_MOD;
      ST_MOD: begin
        state_nxt = (note_ok && ent_mod.active) ? ST_DIV1 : ST_DONE;
      end
      ST_DIV1: state_nxt = ST_WAIT1;
      ST_WAIT1: begin
        if (div_resp.done) begin
          state_nxt = (!ent_r.fading || late_c) ? ST_DONE : ST_MUL2;
        end
      end
      ST_MUL2: state_nxt = ST_DIV2;
      ST_DIV2: state_nxt = ST_WAIT2;
      ST_WAIT2: begin
        if (div_resp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    div_req.start    = (state_r == ST_DIV1) || (state_r == ST_DIV2);
    div_req.dividend = (state_r == ST_DIV1) ? 24'(prod_r) : prod2_r;
    div_req.divisor  = (state_r == ST_DIV1) ? 16'(full_eff) : hold_r;
    res_load         = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_cnt_r  <= '0;
      sustain_r   <= 1'b0;
      hold_r      <= FADE_HOLD_RST;
      full_r      <= FULL_SCALE_RST;
      out_valid_r <= 1'b0;
      ent_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_WALK) && !walk_last) begin
        walk_cnt_r <= walk_cnt_r + WALK_W'(1);
      end else begin
        walk_cnt_r <= '0;
      end
      if (in_valid && in_ready && (in_data.op == OP_CTRL) &&
          (in_data.controller == SUSTAIN_CTRL)) begin
        sustain_r <= (in_data.cc_value >= SUSTAIN_ON_MIN);
      end
      if (cfg_valid && (cfg_index == CFG_FADE_HOLD)) begin
        hold_r <= cfg_data[15:0];
      end
      if (cfg_valid && (cfg_index == CFG_FULL_SCALE)) begin
        full_r <= cfg_data[6:0];
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == ST_MOD) begin
      ent_r             <= ent_mod;
      prod_r            <= 16'(ent_mod.velocity) * 16'(BRIGHT_SPAN);
      res_r.note_active <= note_ok && ent_mod.active;
      res_r.note_fading <= note_ok && ent_mod.fading;
      res_r.brightness  <= '0;
      res_r.hue         <= {item_r.note[6:0], 1'b0};
      res_r.led_index   <= LED_TABLE[item_r.note];
      res_r.sustain_on  <= sustain_r;
    end
    if ((state_r == ST_WAIT1) && div_resp.done) begin
      value_r      <= value_c;
      elapsed_lo_r <= elapsed_c[15:0];
      if (!ent_r.fading) begin
        res_r.brightness <= value_c;
      end
    end
    if (state_r == ST_MUL2) begin
      prod2_r <= 24'(elapsed_lo_r) * 24'(value_r);
    end
    if ((state_r == ST_WAIT2) && div_resp.done) begin
      res_r.brightness <= (div_resp.quotient >= 24'(value_r)) ? 8'd0 :
                          (value_r - div_resp.quotient[7:0]);
    end
    if (res_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `MNLET_ASSERT(a_no_same_entry, wr_en && rd_en, wr_addr != rd_addr)
  `MNLET_ASSERT(a_div_start_idle, div_req.start, !div_resp.busy)
  `MNLET_ASSERT(a_div_done_waiting, div_resp.done, state_r == ST_WAIT1 || state_r == ST_WAIT2)
  `MNLET_ASSERT_NEXT(a_out_loaded, res_load, out_valid_r && (out_data_r == $past(res_r)))

endmodule
